### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// The first form checks with reset gating; the second checks during reset too.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SSC_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SSC_ASSERT(lbl, prop)
`define SSC_ASSERT_NR(lbl, prop)
`endif
`endif

### rtl/sscyl_pkg.sv
// ----------------------------------------------------------------------------
// sscyl_pkg
// Widths and the side-band record of the swept sphere / cylinder test.
// ----------------------------------------------------------------------------
package sscyl_pkg;

    localparam int COORD_W = 24;
    localparam int LEN_W   = 20;
    localparam int IN_W    = 280;
    localparam int OUT_W   = 24;
    localparam int FRAC_W  = 17;
    localparam int DIFF_W  = 25;
    localparam int A_W     = 50;
    localparam int B_W     = 50;
    localparam int C_W     = 51;
    localparam int HALF_W  = 25;
    localparam int PROD_W  = 100;
    localparam int ROOT_W  = 51;
    localparam int DISC_W  = 2 * ROOT_W;
    localparam int HN_W    = 52;
    localparam int VN_W    = 27;
    localparam int VD_W    = 25;

    typedef struct packed {
        logic                    empty;
        logic                    hfail;
        logic                    a_zero;
        logic [A_W-1:0]          a;
        logic signed [B_W-1:0]   b;
        logic                    dy_zero;
        logic                    vfail;
        logic signed [VN_W-1:0]  n1;
        logic signed [VN_W-1:0]  n2;
        logic [VD_W-1:0]         den;
    } side_t;

endpackage

### rtl/sscyl_isqrt.sv
// ----------------------------------------------------------------------------
// sscyl_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sscyl_isqrt #(
    parameter int RB = 51
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RB-1:0] rad,
    output logic [RB-1:0]   root
);
    localparam int DW = 2 * RB;

    logic [DW-1:0] rem_reg [RB-1];
    logic [RB-1:0] res_reg [RB];

    for (genvar k = 0; k < RB; k++)
    begin : g_stage
        localparam int BIT = RB - 1 - k;
        logic [DW-1:0] rem_in;
        logic [RB-1:0] res_in;
        logic [DW-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = rad;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        // (2*res + 2^bit) * 2^bit
        assign trial = (DW'(res_in) << (BIT + 1)) | (DW'(1) << (2 * BIT));
        assign ge    = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[k] <= ge ? (res_in | (RB'(1) << BIT)) : res_in;
            end
        end

        if (k < RB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = res_reg[RB-1];

endmodule

### rtl/sscyl_qdiv.sv
// ----------------------------------------------------------------------------
// sscyl_qdiv
// Pipelined floor(num * 2^FB / den), saturated to -1 .. 2^FB + 1.
// ----------------------------------------------------------------------------
module sscyl_qdiv #(
    parameter int NW = 52,
    parameter int DW = 50,
    parameter int FB = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic signed [FB+2:0] quo
);
    localparam int MW = ((NW - 1 > DW) ? NW - 1 : DW) + 1;
    localparam logic [FB:0] QMAX = (FB+1)'((64'd1 << FB) + 64'd1);

    logic          neg_reg [FB+1];
    logic          sat_reg [FB+1];
    logic [FB:0]   q_reg   [FB+1];
    logic [DW-1:0] r_reg   [FB];
    logic [DW-1:0] d_reg   [FB];
    logic signed [FB+2:0] quo_reg;

    logic [MW-1:0] un;
    logic [MW-1:0] dd;
    logic          q0;
    logic [MW-1:0] r0;

    assign un = MW'(num[NW-2:0]);
    assign dd = MW'(den);
    assign q0 = un >= dd;
    assign r0 = q0 ? (un - dd) : un;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= num[NW-1];
            sat_reg[0] <= (un >> 1) >= dd;
            q_reg[0]   <= (FB+1)'(q0);
            r_reg[0]   <= r0[DW-1:0];
            d_reg[0]   <= den;
        end
    end

    for (genvar k = 1; k <= FB; k++)
    begin : g_step
        logic [DW:0] r2;
        logic [DW:0] diff;
        logic        ge;

        assign r2   = {r_reg[k-1], 1'b0};
        assign diff = r2 - {1'b0, d_reg[k-1]};
        assign ge   = r2 >= {1'b0, d_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][FB-1:0], ge};
            end
        end

        if (k < FB)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k] <= ge ? diff[DW-1:0] : r2[DW-1:0];
                    d_reg[k] <= d_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[FB])
            begin
                quo_reg <= '1;
            end
            else if (sat_reg[FB] || (q_reg[FB] > QMAX))
            begin
                quo_reg <= $signed({2'b00, QMAX});
            end
            else
            begin
                quo_reg <= $signed({2'b00, q_reg[FB]});
            end
        end
    end

    assign quo = quo_reg;

endmodule

### rtl/swept_sphere_cylinder_hit_top.sv
// Stages from input request to result: 7 setup/multiply stages, 51 square
// root stages, 1 bound stage, FRACTION_BITS + 2 divider stages, 1 output
// stage.
// Throughput: one request per cycle; the whole pipeline stalls only while a
// result waits at the output. Reset clears the valid bits, the pipe is empty.
// ----------------------------------------------------------------------------
// swept_sphere_cylinder_hit_top
// Swept sphere against a widened vertical cylinder: hit flag and entry point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swept_sphere_cylinder_hit_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, probe_radius,
    // body_base_x, body_base_y, body_base_z, cyl_radius, cyl_height, pad
    input  logic [sscyl_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // entry_fraction, pad
    output logic [sscyl_pkg::OUT_W-1:0]  m_axis_tdata,
    // hit
    output logic                         m_axis_tuser
);
    import sscyl_pkg::*;

    localparam int QW  = FRACTION_BITS + 3;
    localparam int QD  = FRACTION_BITS + 2;
    localparam int LAT = 7 + ROOT_W + 1 + QD + 1;
    localparam int EW  = (QW > FRAC_W) ? QW : FRAC_W;
    localparam logic signed [QW-1:0] ONE_Q = QW'(64'd1 << FRACTION_BITS);
    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(64'd1 << FRACTION_BITS);

    logic adv;
    logic [LAT-1:0] vld_reg;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // input fields
    logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez, bx, by, bz;
    logic [LEN_W-1:0] pr, br, bh;

    assign sx = s_axis_tdata[23:0];
    assign sy = s_axis_tdata[47:24];
    assign sz = s_axis_tdata[71:48];
    assign ex = s_axis_tdata[95:72];
    assign ey = s_axis_tdata[119:96];
    assign ez = s_axis_tdata[143:120];
    assign pr = s_axis_tdata[163:144];
    assign bx = s_axis_tdata[187:164];
    assign by = s_axis_tdata[211:188];
    assign bz = s_axis_tdata[235:212];
    assign br = s_axis_tdata[255:236];
    assign bh = s_axis_tdata[275:256];

    // stage 1: differences, reach sum and empty flag
    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [DIFF_W-1:0] s1_rx_reg, s1_ry_reg, s1_rz_reg;
    logic [LEN_W:0]   s1_reach_reg;
    logic [LEN_W-1:0] s1_pr_reg, s1_bh_reg;
    logic             s1_empty_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg    <= DIFF_W'(ex) - DIFF_W'(sx);
            s1_dy_reg    <= DIFF_W'(ey) - DIFF_W'(sy);
            s1_dz_reg    <= DIFF_W'(ez) - DIFF_W'(sz);
            s1_rx_reg    <= DIFF_W'(sx) - DIFF_W'(bx);
            s1_ry_reg    <= DIFF_W'(sy) - DIFF_W'(by);
            s1_rz_reg    <= DIFF_W'(sz) - DIFF_W'(bz);
            s1_reach_reg <= (LEN_W+1)'(pr) + (LEN_W+1)'(br);
            s1_pr_reg    <= pr;
            s1_bh_reg    <= bh;
            s1_empty_reg <= (br == '0) || (bh == '0);
        end
    end

    // stage 2: products
    logic signed [2*DIFF_W-1:0] s2_dxdx_reg, s2_dzdz_reg, s2_rxdx_reg;
    logic signed [2*DIFF_W-1:0] s2_rzdz_reg, s2_rxrx_reg, s2_rzrz_reg;
    logic [2*LEN_W+1:0]         s2_rr_reg;
    logic signed [DIFF_W-1:0]   s2_dy_reg, s2_ry_reg;
    logic [LEN_W-1:0]           s2_pr_reg, s2_bh_reg;
    logic                       s2_empty_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_dxdx_reg  <= s1_dx_reg * s1_dx_reg;
            s2_dzdz_reg  <= s1_dz_reg * s1_dz_reg;
            s2_rxdx_reg  <= s1_rx_reg * s1_dx_reg;
            s2_rzdz_reg  <= s1_rz_reg * s1_dz_reg;
            s2_rxrx_reg  <= s1_rx_reg * s1_rx_reg;
            s2_rzrz_reg  <= s1_rz_reg * s1_rz_reg;
            s2_rr_reg    <= s1_reach_reg * s1_reach_reg;
            s2_dy_reg    <= s1_dy_reg;
            s2_ry_reg    <= s1_ry_reg;
            s2_pr_reg    <= s1_pr_reg;
            s2_bh_reg    <= s1_bh_reg;
            s2_empty_reg <= s1_empty_reg;
        end
    end

    // stage 3: quadratic terms and vertical slab numerators
    side_t s3_side_next, s3_side_reg;
    logic signed [C_W-1:0]  s3_c_next, s3_c_reg;
    logic signed [VN_W-1:0] v_n1, v_n2, v_ry, v_pr, v_bh;

    always_comb
    begin
        v_ry = VN_W'(s2_ry_reg);
        v_pr = $signed({7'b0, s2_pr_reg});
        v_bh = $signed({7'b0, s2_bh_reg});
        v_n1 = -v_pr - v_ry;
        v_n2 = v_bh + v_pr - v_ry;

        s3_side_next.empty   = s2_empty_reg;
        s3_side_next.hfail   = 1'b0;
        s3_side_next.a       = A_W'(s2_dxdx_reg) + A_W'(s2_dzdz_reg);
        s3_side_next.a_zero  = 1'b0;
        s3_side_next.b       = B_W'(s2_rxdx_reg) + B_W'(s2_rzdz_reg);
        s3_side_next.dy_zero = (s2_dy_reg == '0);
        // flat motion: inside the slab or no hit
        s3_side_next.vfail   = (s2_dy_reg == '0) && ((v_n1 > 0) || (v_n2 < 0));
        if (s2_dy_reg < 0)
        begin
            s3_side_next.n1  = -v_n1;
            s3_side_next.n2  = -v_n2;
            s3_side_next.den = VD_W'(-s2_dy_reg);
        end
        else
        begin
            s3_side_next.n1  = v_n1;
            s3_side_next.n2  = v_n2;
            s3_side_next.den = VD_W'(s2_dy_reg);
        end
        s3_c_next = C_W'(s2_rxrx_reg) + C_W'(s2_rzrz_reg) - $signed({9'b0, s2_rr_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= s3_side_next;
            s3_c_reg    <= s3_c_next;
        end
    end

    // stage 4: magnitudes
    side_t          s4_side_next, s4_side_reg;
    logic [B_W-1:0] s4_bmag_reg;
    logic [A_W-1:0] s4_cmag_reg;
    logic           s4_cneg_reg, s4_cpos_reg;
    logic signed [C_W-1:0] c_abs;

    assign c_abs = (s3_c_reg < 0) ? -s3_c_reg : s3_c_reg;

    always_comb
    begin
        s4_side_next        = s3_side_reg;
        s4_side_next.a_zero = (s3_side_reg.a == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg        <= s4_side_next;
            s4_bmag_reg        <= (s3_side_reg.b < 0) ? B_W'(-s3_side_reg.b)
                                                      : B_W'(s3_side_reg.b);
            s4_cmag_reg        <= A_W'(c_abs);
            s4_cneg_reg        <= s3_c_reg < 0;
            s4_cpos_reg        <= s3_c_reg > 0;
        end
    end

    // stage 5: partial products of b*b and a*|c|
    side_t               s5_side_reg;
    logic [2*HALF_W-1:0] s5_bhh_reg, s5_bhl_reg, s5_bll_reg;
    logic [2*HALF_W-1:0] s5_ahh_reg, s5_ahl_reg, s5_alh_reg, s5_all_reg;
    logic                s5_cneg_reg, s5_cpos_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg <= s4_side_reg;
            s5_bhh_reg  <= s4_bmag_reg[49:25] * s4_bmag_reg[49:25];
            s5_bhl_reg  <= s4_bmag_reg[49:25] * s4_bmag_reg[24:0];
            s5_bll_reg  <= s4_bmag_reg[24:0] * s4_bmag_reg[24:0];
            s5_ahh_reg  <= s4_side_reg.a[49:25] * s4_cmag_reg[49:25];
            s5_ahl_reg  <= s4_side_reg.a[49:25] * s4_cmag_reg[24:0];
            s5_alh_reg  <= s4_side_reg.a[24:0] * s4_cmag_reg[49:25];
            s5_all_reg  <= s4_side_reg.a[24:0] * s4_cmag_reg[24:0];
            s5_cneg_reg <= s4_cneg_reg;
            s5_cpos_reg <= s4_cpos_reg;
        end
    end

    // stage 6: full products
    side_t             s6_side_reg;
    logic [PROD_W-1:0] s6_bb_reg, s6_ac_reg;
    logic              s6_cneg_reg, s6_cpos_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_side_reg <= s5_side_reg;
            s6_bb_reg   <= (PROD_W'(s5_bhh_reg) << 50) + (PROD_W'(s5_bhl_reg) << 26)
                         + PROD_W'(s5_bll_reg);
            s6_ac_reg   <= (PROD_W'(s5_ahh_reg) << 50)
                         + ((PROD_W'(s5_ahl_reg) + PROD_W'(s5_alh_reg)) << 25)
                         + PROD_W'(s5_all_reg);
            s6_cneg_reg <= s5_cneg_reg;
            s6_cpos_reg <= s5_cpos_reg;
        end
    end

    // stage 7: discriminant
    side_t             s7_side_next, s7_side_reg;
    logic [DISC_W-1:0] s7_disc_reg;

    always_comb
    begin
        s7_side_next       = s6_side_reg;
        // no motion: containment; else a negative discriminant misses
        s7_side_next.hfail = s6_side_reg.a_zero ? s6_cpos_reg
                           : (!s6_cneg_reg && (s6_bb_reg < s6_ac_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_side_reg       <= s7_side_next;
            s7_disc_reg       <= s6_cneg_reg ? (DISC_W'(s6_bb_reg) + DISC_W'(s6_ac_reg))
                                             : (DISC_W'(s6_bb_reg) - DISC_W'(s6_ac_reg));
        end
    end

    logic [ROOT_W-1:0] root;
    side_t             sq_side_reg [ROOT_W];

    sscyl_isqrt #(
        .RB   (ROOT_W)
    ) u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (s7_disc_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= s7_side_reg;
            for (int i = 1; i < ROOT_W; i++)
            begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    // bound numerators
    side_t                  n_side_reg;
    logic signed [HN_W-1:0] n_lo_reg, n_hi_reg;
    logic signed [HN_W-1:0] nb, nr;

    assign nb = HN_W'(sq_side_reg[ROOT_W-1].b);
    assign nr = $signed({1'b0, root});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_side_reg <= sq_side_reg[ROOT_W-1];
            n_lo_reg   <= -nb - nr;
            n_hi_reg   <= nr - nb;
        end
    end

    logic signed [QW-1:0] q_lo, q_hi, q_v1, q_v2;
    side_t                q_side_reg [QD];

    sscyl_qdiv #(.NW(HN_W), .DW(A_W), .FB(FRACTION_BITS)) u_qdiv_lo (
        .clk (clk), .en (adv), .num (n_lo_reg), .den (n_side_reg.a), .quo (q_lo)
    );

    sscyl_qdiv #(.NW(HN_W), .DW(A_W), .FB(FRACTION_BITS)) u_qdiv_hi (
        .clk (clk), .en (adv), .num (n_hi_reg), .den (n_side_reg.a), .quo (q_hi)
    );

    sscyl_qdiv #(.NW(VN_W), .DW(VD_W), .FB(FRACTION_BITS)) u_qdiv_v1 (
        .clk (clk), .en (adv), .num (n_side_reg.n1), .den (n_side_reg.den), .quo (q_v1)
    );

    sscyl_qdiv #(.NW(VN_W), .DW(VD_W), .FB(FRACTION_BITS)) u_qdiv_v2 (
        .clk (clk), .en (adv), .num (n_side_reg.n2), .den (n_side_reg.den), .quo (q_v2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_side_reg[0] <= n_side_reg;
            for (int i = 1; i < QD; i++)
            begin
                q_side_reg[i] <= q_side_reg[i-1];
            end
        end
    end

    // interval combine
    side_t                fs;
    logic signed [QW-1:0] v_min, v_max, enter, leave;
    logic [EW-1:0]        enter_w;
    logic                 hit_next;
    logic [FRAC_W-1:0]    frac_next;
    logic                 out_hit_reg;
    logic [FRAC_W-1:0]    out_frac_reg;

    always_comb
    begin
        fs    = q_side_reg[QD-1];
        v_min = (q_v1 < q_v2) ? q_v1 : q_v2;
        v_max = (q_v1 < q_v2) ? q_v2 : q_v1;
        enter = '0;
        leave = ONE_Q;
        if (!fs.a_zero)
        begin
            if (q_lo > enter)
            begin
                enter = q_lo;
            end
            if (q_hi < leave)
            begin
                leave = q_hi;
            end
        end
        if (!fs.dy_zero)
        begin
            if (v_min > enter)
            begin
                enter = v_min;
            end
            if (v_max < leave)
            begin
                leave = v_max;
            end
        end
        enter_w   = EW'(enter);
        hit_next  = !fs.empty && !fs.hfail && !fs.vfail && (enter <= leave);
        frac_next = hit_next ? enter_w[FRAC_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg  <= hit_next;
            out_frac_reg <= frac_next;
        end
    end

    assign m_axis_tuser = out_hit_reg;
    assign m_axis_tdata = OUT_W'(out_frac_reg);

    `SSC_ASSERT(a_miss_zero, m_axis_tvalid && !m_axis_tuser |-> out_frac_reg == '0)
    `SSC_ASSERT(a_frac_range, m_axis_tvalid && (FRACTION_BITS <= 16) |-> out_frac_reg <= FRAC_MAX)
    `SSC_ASSERT(a_stall_hold, !adv |=> $stable(vld_reg) && $stable(out_frac_reg))
    `SSC_ASSERT_NR(a_reset_idle, !rst_n |-> !m_axis_tvalid)

endmodule
